// ----- hdl/bole_pkg.sv -----
// ---------------------------------------------------------------------------
// bole_pkg: shared types and constants of the ordered list engine
// Holds capacity, widths, command and status codes and the queued command.
// ---------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned IdxW      = $clog2(Capacity);
  localparam int unsigned CntW      = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    MODE_INS_HEAD  = 4'd0,
    MODE_INS_TAIL  = 4'd1,
    MODE_INS_AT    = 4'd2,
    MODE_DEL_HEAD  = 4'd3,
    MODE_DEL_FIRST = 4'd4,
    MODE_DEL_LAST  = 4'd5,
    MODE_DEL_AT    = 4'd6,
    MODE_SEARCH    = 4'd7,
    MODE_GET_AT    = 4'd8
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [3:0]           mode;
    logic [6:0]           position;
    logic [ValueBits-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_SHIFT,
    BS_WRITE,
    BS_READ,
    BS_DONE
  } back_state_e;

  // Cut a 32-bit field to the stored width, sign extended.
  function automatic logic [ValueBits-1:0] norm_value(input logic [31:0] raw);
    logic [63:0] ext;
    ext = {{32{raw[31]}}, raw};
    return ext[ValueBits-1:0];
  endfunction

endpackage

// ----- hdl/bole_ram.sv -----
// ---------------------------------------------------------------------------
// bole_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module bole_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- hdl/bole_front.sv -----
// ---------------------------------------------------------------------------
// bole_front: command intake
// Normalizes and queues commands in a two-entry FIFO for the back end.
// ---------------------------------------------------------------------------
module bole_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3:0]          mode_i,
  input  logic [6:0]          position_i,
  input  logic signed [31:0]  item_value_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output bole_pkg::cmd_t      cmd_o
);
  bole_pkg::cmd_t fifo_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     fill_q;
  logic           push, pop;

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{mode: mode_i, position: position_i,
                            value: bole_pkg::norm_value(item_value_i)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- hdl/bole_back.sv -----
// ---------------------------------------------------------------------------
// bole_back: list executor
// Walks the entry RAM to scan one word per cycle, to shift by reading then writing each word, and to write and read.
// ---------------------------------------------------------------------------
module bole_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  bole_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [5:0]          found_index_o,
  output logic signed [31:0]  read_value_o,
  output logic [6:0]          entry_count_o
);
  localparam int unsigned IdxW = bole_pkg::IdxW;
  localparam int unsigned CntW = bole_pkg::CntW;
  localparam int unsigned VB   = bole_pkg::ValueBits;

  bole_pkg::back_state_e state_q, state_d;
  bole_pkg::cmd_t        cmd_q;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       ptr_q, ptr_d;     // scan or shift pointer
  logic [CntW-1:0]       tgt_q, tgt_d;     // target index
  logic                  hit_q, hit_d;
  logic                  rd_pend_q, rd_pend_d;
  logic                  ins_q, ins_d;     // shift direction: insert
  logic [2:0]            st_q, st_d;
  logic [5:0]            fidx_q, fidx_d;
  logic [VB-1:0]         rval_q, rval_d;
  logic                  out_v_q, out_v_d;

  logic                  we;
  logic [IdxW-1:0]       addr;
  logic [VB-1:0]         wdata, rdata;
  logic [CntW-1:0]       rd_addr_q, rd_addr_d;

  bole_ram #(.Width(VB), .Depth(bole_pkg::Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign cmd_ready_o   = (state_q == bole_pkg::BS_IDLE) && !out_v_q;
  assign out_valid_o   = out_v_q;
  assign status_o      = st_q;
  assign found_index_o = fidx_q;
  assign read_value_o  = 32'(signed'(rval_q));
  assign entry_count_o = 7'(count_q);

  // Next-state and datapath control.
  always_comb begin
    logic [CntW-1:0] pos;
    logic            match;
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    tgt_d     = tgt_q;
    hit_d     = hit_q;
    rd_pend_d = 1'b0;
    ins_d     = ins_q;
    st_d      = st_q;
    fidx_d    = fidx_q;
    rval_d    = rval_q;
    out_v_d   = out_v_q && !out_ready_i;
    rd_addr_d = rd_addr_q;
    we        = 1'b0;
    addr      = rd_addr_q[IdxW-1:0];
    wdata     = cmd_q.value;
    pos       = (CntW > 7) ? CntW'(cmd_i.position) : cmd_i.position[CntW-1:0];
    match     = (rdata == cmd_q.value);
    unique case (state_q)
      bole_pkg::BS_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          st_d   = bole_pkg::ST_OK;
          fidx_d = '0;
          rval_d = '0;
          hit_d  = 1'b0;
          ptr_d  = '0;
          state_d = bole_pkg::BS_DONE;
          unique case (cmd_i.mode) inside
            bole_pkg::MODE_INS_HEAD, bole_pkg::MODE_INS_TAIL,
            bole_pkg::MODE_INS_AT: begin
              if (cmd_i.mode == bole_pkg::MODE_INS_AT &&
                  7'(cmd_i.position) > 7'(count_q))
                st_d = bole_pkg::ST_RANGE;
              else if (count_q >= CntW'(bole_pkg::Capacity))
                st_d = bole_pkg::ST_FULL;
              else begin
                tgt_d = (cmd_i.mode == bole_pkg::MODE_INS_HEAD) ? '0 :
                        (cmd_i.mode == bole_pkg::MODE_INS_TAIL) ? count_q : pos;
                ptr_d = count_q;
                ins_d = 1'b1;
                state_d = bole_pkg::BS_SHIFT;
              end
            end
            bole_pkg::MODE_DEL_HEAD: begin
              if (count_q == '0) st_d = bole_pkg::ST_EMPTY;
              else begin
                tgt_d = '0; ptr_d = '0; ins_d = 1'b0;
                state_d = bole_pkg::BS_SHIFT;
              end
            end
            bole_pkg::MODE_DEL_FIRST, bole_pkg::MODE_DEL_LAST,
            bole_pkg::MODE_SEARCH: begin
              if (count_q == '0)
                st_d = (cmd_i.mode == bole_pkg::MODE_SEARCH) ?
                       bole_pkg::ST_NOTFOUND : bole_pkg::ST_EMPTY;
              else begin
                // Issue the read of entry zero now.
                addr      = '0;
                rd_addr_d = '0;
                rd_pend_d = 1'b1;
                state_d = bole_pkg::BS_SCAN;
              end
            end
            bole_pkg::MODE_DEL_AT: begin
              if (7'(cmd_i.position) >= 7'(count_q)) st_d = bole_pkg::ST_RANGE;
              else begin
                tgt_d = pos; ptr_d = pos; ins_d = 1'b0;
                state_d = bole_pkg::BS_SHIFT;
              end
            end
            bole_pkg::MODE_GET_AT: begin
              if (count_q == '0) st_d = bole_pkg::ST_EMPTY;
              else if (7'(cmd_i.position) >= 7'(count_q)) st_d = bole_pkg::ST_RANGE;
              else begin
                rd_addr_d = pos;
                state_d = bole_pkg::BS_READ;
              end
            end
            default: ;
          endcase
        end
      end
      bole_pkg::BS_READ: begin
        // RAM read issued from rd_addr_q this cycle, data next cycle.
        if (rd_pend_q) begin
          rval_d  = rdata;
          state_d = bole_pkg::BS_DONE;
        end else begin
          rd_pend_d = 1'b1;
        end
      end
      bole_pkg::BS_SCAN: begin
        // rdata holds entry ptr_q; the next address is issued here if the scan goes on.
        if (rd_pend_q) begin
          if (match) begin
            hit_d = 1'b1;
            tgt_d = ptr_q;
          end
          if ((match && cmd_q.mode != bole_pkg::MODE_DEL_LAST) ||
              ptr_q + 1'b1 == count_q) begin
            if (!(match || hit_q)) st_d = bole_pkg::ST_NOTFOUND;
            if (cmd_q.mode == bole_pkg::MODE_SEARCH) begin
              if (match) fidx_d = 6'(ptr_q);
              state_d = bole_pkg::BS_DONE;
            end else if (match || hit_q) begin
              ptr_d = match ? ptr_q : tgt_q;
              ins_d = 1'b0;
              state_d = bole_pkg::BS_SHIFT;
            end else state_d = bole_pkg::BS_DONE;
          end else begin
            ptr_d     = ptr_q + 1'b1;
            rd_addr_d = rd_addr_q + 1'b1;
            addr      = rd_addr_d[IdxW-1:0];
            rd_pend_d = 1'b1;
          end
        end
      end
      bole_pkg::BS_SHIFT: begin
        // Alternate read (rd_pend=0) and write (rd_pend=1) of one word.
        if (ins_q) begin
          if (ptr_q == tgt_q) begin
            state_d = bole_pkg::BS_WRITE;
          end else if (!rd_pend_q) begin
            addr = IdxW'(ptr_q - 1'b1);
            rd_pend_d = 1'b1;
          end else begin
            we = 1'b1; addr = ptr_q[IdxW-1:0]; wdata = rdata;
            ptr_d = ptr_q - 1'b1;
          end
        end else begin
          if (ptr_q + 1'b1 >= count_q) begin
            count_d = count_q - 1'b1;
            state_d = bole_pkg::BS_DONE;
          end else if (!rd_pend_q) begin
            addr = IdxW'(ptr_q + 1'b1);
            rd_pend_d = 1'b1;
          end else begin
            we = 1'b1; addr = ptr_q[IdxW-1:0]; wdata = rdata;
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      bole_pkg::BS_WRITE: begin
        we = 1'b1; addr = tgt_q[IdxW-1:0]; wdata = cmd_q.value;
        count_d = count_q + 1'b1;
        state_d = bole_pkg::BS_DONE;
      end
      bole_pkg::BS_DONE: begin
        out_v_d = 1'b1;
        state_d = bole_pkg::BS_IDLE;
      end
      default: state_d = bole_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    tgt_q     <= tgt_d;
    ptr_q     <= ptr_d;
    hit_q     <= hit_d;
    ins_q     <= ins_d;
    st_q      <= st_d;
    fidx_q    <= fidx_d;
    rval_q    <= rval_d;
    rd_addr_q <= rd_addr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bole_pkg::BS_IDLE;
      count_q   <= '0;
      out_v_q   <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_v_q   <= out_v_d;
      rd_pend_q <= rd_pend_d;
    end
  end
endmodule

// ----- hdl/bounded_ordered_list_engine.sv -----
// ---------------------------------------------------------------------------
// bounded_ordered_list_engine: bounded ordered list of signed values
// Insert, delete, search and read by index over a 64-entry RAM.
// ---------------------------------------------------------------------------
// Each command transaction yields exactly one result transaction. A two-entry
// command queue accepts commands while the executor works. The executor owns
// one single-port RAM, so each step costs one RAM access. A search or match
// delete scans one entry per cycle, and a shifting insert or delete reads and
// then writes each entry moved. The worst case is a last-match delete that
// scans the whole list and then shifts all of it. Results are held in an
// output register until taken, and the executor takes no new command while a
// result waits.
module bounded_ordered_list_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         mode_i,
  input  logic [6:0]         position_i,
  input  logic signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [5:0]         found_index_o,
  output logic signed [31:0] read_value_o,
  output logic [6:0]         entry_count_o
);
  logic           cmd_valid, cmd_ready;
  bole_pkg::cmd_t cmd;

  // Accept and queue commands.
  bole_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .position_i,
    .item_value_i, .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // Execute against the entry RAM.
  bole_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .out_valid_o, .out_ready_i, .status_o, .found_index_o,
    .read_value_o, .entry_count_o
  );
endmodule

// ----- hdl/bole_checker.sv -----
// ---------------------------------------------------------------------------
// bole_checker: port-level checks of the list engine
// Watches status codes, count bounds and output stability.
// ---------------------------------------------------------------------------
module bole_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [5:0] found_index_o,
  input logic [6:0] entry_count_o
);
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= 7'(bole_pkg::Capacity))
    else $error("count beyond capacity");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= bole_pkg::ST_FULL)
    else $error("bad status");

  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bole_pkg::ST_OK |-> found_index_o == '0)
    else $error("found index set on failure");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_count_o))
    else $error("result dropped");
endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .status_o, .found_index_o,
  .entry_count_o
);

// ----- bench/bounded_ordered_list_engine_tb.sv -----
// ---------------------------------------------------------------------------
// bounded_ordered_list_engine_tb: self-checking bench of the ordered list
// Drives list commands in bursts, predicts every result from a shadow list
// and compares each result transaction field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_ordered_list_engine_tb;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  found_index;
    logic [31:0] read_value;
    logic [6:0]  entry_count;
  } list_result_t;

  // Shadow list plus the queue of results that the engine still owes.
  class list_scoreboard;
    logic [31:0]  shadow[$];
    list_result_t owed[$];
    int unsigned  mismatches;

    // Work out the result of one accepted command and update the shadow list.
    function void note_command(logic [3:0] mode, logic [6:0] pos, logic [31:0] val);
      list_result_t r;
      int unsigned  cnt;
      int           hit;
      r = '{bole_pkg::ST_OK, 6'd0, 32'd0, 7'd0};
      cnt = shadow.size();
      hit = -1;
      case (mode) inside
        bole_pkg::MODE_INS_HEAD, bole_pkg::MODE_INS_TAIL, bole_pkg::MODE_INS_AT: begin
          if (mode == bole_pkg::MODE_INS_AT && pos > cnt) r.status = bole_pkg::ST_RANGE;
          else if (cnt >= bole_pkg::Capacity) r.status = bole_pkg::ST_FULL;
          else if (mode == bole_pkg::MODE_INS_HEAD) shadow.push_front(val);
          else if (mode == bole_pkg::MODE_INS_TAIL) shadow.push_back(val);
          else shadow.insert(pos, val);
        end
        bole_pkg::MODE_DEL_HEAD: begin
          if (cnt == 0) r.status = bole_pkg::ST_EMPTY;
          else void'(shadow.pop_front());
        end
        bole_pkg::MODE_DEL_FIRST, bole_pkg::MODE_DEL_LAST: begin
          if (cnt == 0) r.status = bole_pkg::ST_EMPTY;
          else begin
            foreach (shadow[i])
              if (shadow[i] == val && (hit < 0 || mode == bole_pkg::MODE_DEL_LAST))
                hit = i;
            if (hit < 0) r.status = bole_pkg::ST_NOTFOUND;
            else shadow.delete(hit);
          end
        end
        bole_pkg::MODE_DEL_AT: begin
          if (pos >= cnt) r.status = bole_pkg::ST_RANGE;
          else shadow.delete(pos);
        end
        bole_pkg::MODE_SEARCH: begin
          foreach (shadow[i])
            if (shadow[i] == val && hit < 0) hit = i;
          if (hit < 0) r.status = bole_pkg::ST_NOTFOUND;
          else r.found_index = hit[5:0];
        end
        bole_pkg::MODE_GET_AT: begin
          if (cnt == 0) r.status = bole_pkg::ST_EMPTY;
          else if (pos >= cnt) r.status = bole_pkg::ST_RANGE;
          else r.read_value = shadow[pos];
        end
        default: ;
      endcase
      r.entry_count = 7'(shadow.size());
      owed.push_back(r);
    endfunction

    // Compare one result transaction with the oldest owed result.
    function void check_result(list_result_t got);
      list_result_t exp;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", got.status);
        return;
      end
      exp = owed.pop_front();
      if (got != exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st %0d idx %0d rd %h cnt %0d,",
                    " got st %0d idx %0d rd %h cnt %0d"},
                   exp.status, exp.found_index, exp.read_value, exp.entry_count,
                   got.status, got.found_index, got.read_value, got.entry_count);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [3:0]         mode_i = '0;
  logic [6:0]         position_i = '0;
  logic signed [31:0] item_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic [5:0]         found_index_o;
  logic signed [31:0] read_value_o;
  logic [6:0]         entry_count_o;

  list_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  bit             stall_wild = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bounded_ordered_list_engine i_dut (.*);

  // Bound the run with a timeout that allows for the worst-case command plus stalls, many times over.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2_000_000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall on a pattern that switches at random between calm and heavy stretches.
  always @(posedge clk_i) begin
    if (cycle_count % 500 == 0) stall_wild <= $urandom_range(0, 1);
    if (!stall_wild) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  // Check every accepted result transaction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{status_o, found_index_o, read_value_o, entry_count_o});
  end

  // Hold one command until accepted and note it; valid stays up for the next one.
  task automatic send_command(logic [3:0] mode, logic [6:0] pos, logic [31:0] val);
    mode_i       <= mode;
    position_i   <= pos;
    item_value_i <= val;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(mode, pos, val);
  endtask

  // Drop valid and idle for a number of cycles.
  task automatic idle_cycles(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Pick a value: mostly from a small pool so matches happen, sometimes wide.
  function automatic logic [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 7);
    if (sel < 7) return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    if (sel < 8 && sb.shadow.size() > 0)
      return sb.shadow[$urandom_range(0, sb.shadow.size() - 1)];
    return $urandom();
  endfunction

  // Random command with a bias that walks the count between empty and full.
  task automatic send_random(int unsigned fill_bias);
    logic [3:0]  mode;
    logic [6:0]  pos;
    int unsigned cnt;
    cnt = sb.shadow.size();
    if ($urandom_range(0, 99) < 4) mode = 4'($urandom_range(9, 15));
    else if ($urandom_range(0, 99) < fill_bias) mode = 4'($urandom_range(0, 2));
    else mode = 4'($urandom_range(3, 8));
    if ($urandom_range(0, 9) == 0) pos = 7'($urandom());
    else pos = 7'($urandom_range(0, cnt + 1));
    send_command(mode, pos, pick_value());
  endtask

  initial begin
    int unsigned burst;
    int unsigned bias;
    int unsigned gap;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list corners, extremes, ordering and unused mode.
    send_command(bole_pkg::MODE_DEL_HEAD, 7'd0, 32'd0);
    send_command(bole_pkg::MODE_DEL_FIRST, 7'd0, 32'd1);
    send_command(bole_pkg::MODE_DEL_LAST, 7'd0, 32'd1);
    send_command(bole_pkg::MODE_DEL_AT, 7'd0, 32'd0);
    send_command(bole_pkg::MODE_SEARCH, 7'd0, 32'd0);
    send_command(bole_pkg::MODE_GET_AT, 7'd0, 32'd0);
    send_command(bole_pkg::MODE_INS_AT, 7'd1, 32'd5);
    send_command(bole_pkg::MODE_INS_AT, 7'd0, 32'h7fff_ffff);
    send_command(bole_pkg::MODE_INS_HEAD, 7'd0, 32'h8000_0000);
    send_command(bole_pkg::MODE_INS_TAIL, 7'd127, 32'hffff_ffff);
    send_command(bole_pkg::MODE_INS_AT, 7'd1, 32'h7fff_ffff);
    send_command(bole_pkg::MODE_SEARCH, 7'd0, 32'h7fff_ffff);
    send_command(bole_pkg::MODE_DEL_LAST, 7'd0, 32'h7fff_ffff);
    send_command(bole_pkg::MODE_GET_AT, 7'd127, 32'd0);
    send_command(bole_pkg::MODE_GET_AT, 7'd2, 32'd0);
    send_command(bole_pkg::MODE_DEL_FIRST, 7'd0, 32'd9);
    send_command(bole_pkg::MODE_DEL_AT, 7'd3, 32'd0);
    send_command(bole_pkg::MODE_DEL_AT, 7'd0, 32'd0);
    send_command(4'd15, 7'd127, 32'hffff_ffff);
    // Fill to capacity, then overflow with every insert flavor.
    while (sb.shadow.size() < bole_pkg::Capacity)
      send_command(bole_pkg::MODE_INS_TAIL, 7'd0, $urandom_range(0, 7));
    send_command(bole_pkg::MODE_INS_HEAD, 7'd0, 32'd1);
    send_command(bole_pkg::MODE_INS_TAIL, 7'd0, 32'd1);
    send_command(bole_pkg::MODE_INS_AT, 7'd64, 32'd1);
    send_command(bole_pkg::MODE_INS_AT, 7'd65, 32'd1);
    send_command(bole_pkg::MODE_GET_AT, 7'd63, 32'd0);

    // Random bursts; the fill bias drifts so the count sweeps its range.
    bias = 50;
    for (int n = 0; n < 1060;) begin
      burst = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) bias = $urandom_range(20, 80);
      for (int b = 0; b < burst; b++, n++) send_random(bias);
      gap = $urandom_range(0, 20);
      if (gap != 0) idle_cycles(gap);
    end
    idle_cycles(1);

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bole_pkg.sv
hdl/bole_ram.sv
hdl/bole_front.sv
hdl/bole_back.sv
hdl/bounded_ordered_list_engine.sv
hdl/bole_checker.sv
bench/bounded_ordered_list_engine_tb.sv
